>>> rtl/gtq_pkg.sv
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types and constants of the grouped team FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package gtq_pkg;

  localparam int unsigned DEF_ELEMENTS = 4096;
  localparam int unsigned DEF_TEAMS    = 64;
  localparam int unsigned DEF_CAPACITY = 1024;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ELEM_W  = 12;
  localparam int unsigned TEAM_W  = 6;
  localparam int unsigned STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_BIND  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ELEM_W-1:0] element;
    logic [TEAM_W-1:0] team_id;
  } req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] out_value;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic              latch;
    logic              mod1;
    logic              mod2;
    logic              mod3;
    logic              bind_wr;
    logic              mem_rd;
    logic              enq_look;
    logic              enq_commit;
    logic              order_rd;
    logic              deq_look;
    logic              deq_slot;
    logic              deq_commit;
    logic              clear;
    logic              respond;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             full;
    logic             empty;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/grouped_team_fifo_queue.sv
// ----------------------------------------------------------------------------
// grouped_team_fifo_queue
// Team queue: words of one team stand together, teams leave in arrival order.
// ----------------------------------------------------------------------------
// done_o is registered from the final state: DECODE for clear and empty
// dequeue, MOD3 for a full enqueue, BIND for bind, E3 and D4 for the rest.
// One request at a time, paced by a chain of registered reads: membership
// (team order for dequeue), then team count/pointers, then slot links/values.
// The next request is accepted during the done_o cycle; no output stall.
// Reset clears counts, free list and team order at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_team_fifo_queue
  import gtq_pkg::*;
#(
  parameter int unsigned ELEMENTS = DEF_ELEMENTS,
  parameter int unsigned TEAMS    = DEF_TEAMS,
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  cmd_t cmd;
  sts_t sts;

  gtq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gtq_dpath #(
    .ELEMENTS (ELEMENTS),
    .TEAMS    (TEAMS),
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/gtq_ram.sv
// ----------------------------------------------------------------------------
// gtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gtq_ctrl.sv
// ----------------------------------------------------------------------------
// gtq_ctrl
// Request sequencer: steps each request through decode and, as its type needs, modulo, lookup and commit phases.
// ----------------------------------------------------------------------------
`default_nettype none

module gtq_ctrl
  import gtq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MOD2, S_MOD3, S_BIND,
    S_E1, S_E2, S_E3, S_D2, S_D3, S_D4
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.mod1 = 1'b1;
        case (sts_i.req_type)
          REQ_BIND, REQ_ENQ: state_d = S_MOD2;
          REQ_DEQ: begin
            if (sts_i.empty) begin
              cmd_o.respond = 1'b1;
              cmd_o.status  = ST_EMPTY;
              state_d       = S_IDLE;
            end else begin
              cmd_o.order_rd = 1'b1;
              state_d        = S_D2;
            end
          end
          default: begin
            cmd_o.clear   = 1'b1;
            cmd_o.respond = 1'b1;
            cmd_o.status  = ST_OK;
            state_d       = S_IDLE;
          end
        endcase
      end
      S_MOD2: begin
        cmd_o.mod2 = 1'b1;
        state_d    = S_MOD3;
      end
      S_MOD3: begin
        cmd_o.mod3 = 1'b1;
        if (sts_i.req_type == REQ_BIND) begin
          state_d = S_BIND;
        end else if (sts_i.full) begin
          cmd_o.respond = 1'b1;
          cmd_o.status  = ST_FULL;
          state_d       = S_IDLE;
        end else begin
          state_d = S_E1;
        end
      end
      S_BIND: begin
        cmd_o.bind_wr = 1'b1;
        cmd_o.respond = 1'b1;
        cmd_o.status  = ST_OK;
        state_d       = S_IDLE;
      end
      S_E1: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_E2;
      end
      S_E2: begin
        cmd_o.enq_look = 1'b1;
        state_d        = S_E3;
      end
      S_E3: begin
        cmd_o.enq_commit = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_IDLE;
      end
      S_D2: begin
        cmd_o.deq_look = 1'b1;
        state_d        = S_D3;
      end
      S_D3: begin
        cmd_o.deq_slot = 1'b1;
        state_d        = S_D4;
      end
      S_D4: begin
        cmd_o.deq_commit = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gtq_dpath.sv
// ----------------------------------------------------------------------------
// gtq_dpath
// Datapath: membership store, per-team linked lists, free list, team order.
// ----------------------------------------------------------------------------
`default_nettype none

module gtq_dpath
  import gtq_pkg::*;
#(
  parameter int unsigned ELEMENTS = DEF_ELEMENTS,
  parameter int unsigned TEAMS    = DEF_TEAMS,
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int unsigned EW = $clog2(ELEMENTS);
  localparam int unsigned TW = $clog2(TEAMS);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned Recip = (1 << 24) / ELEMENTS;

  req_t            req_q;
  logic [11:0]     quo_q;
  logic [EW:0]     rem_q;
  logic [EW-1:0]   elem_q;
  logic [TW-1:0]   team_q;
  logic [SW-1:0]   slot_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   total_q;
  logic [SW-1:0]   free_head_q;
  logic [SW:0]     fresh_q;
  logic [TW-1:0]   order_head_q;
  logic [TW-1:0]   order_tail_q;
  logic [TEAMS-1:0] cnt_vld_q;
  logic            done_q;
  rsp_t            rsp_q;

  logic [36:0]     prod;
  logic [33:0]     rem_full;
  logic [TW-1:0]   team_tab [64];

  logic [TW-1:0]   mem_rdata, order_rdata;
  logic [CW-1:0]   cnt_rdata, cnt_cur;
  logic [SW-1:0]   head_rdata, tail_rdata, next_rdata;
  logic [ELEM_W-1:0] val_rdata;

  logic            fresh_hit;
  logic [SW-1:0]   next_free;
  logic            enq_new;

  logic            head_we, next_we;
  logic [SW-1:0]   head_wdata, next_waddr, next_raddr;

  for (genvar g = 0; g < 64; g++) begin : g_team_tab
    assign team_tab[g] = TW'(g % TEAMS);
  end

  assign prod     = 37'(req_q.element) * 37'(Recip);
  assign rem_full = 34'(req_q.element) - 34'(quo_q) * 34'(ELEMENTS);

  assign cnt_cur   = cnt_vld_q[team_q] ? cnt_rdata : '0;
  assign enq_new   = (cnt_cur == '0);
  assign fresh_hit = ({1'b0, free_head_q} == fresh_q);
  assign next_free = fresh_hit
                   ? ((free_head_q == SW'(CAPACITY - 1)) ? '0 : free_head_q + SW'(1))
                   : next_rdata;

  assign head_we    = (cmd_i.enq_commit && enq_new) || cmd_i.deq_commit;
  assign head_wdata = cmd_i.deq_commit ? next_rdata : free_head_q;
  assign next_we    = (cmd_i.enq_commit && !enq_new) || cmd_i.deq_commit;
  assign next_waddr = cmd_i.deq_commit ? slot_q : tail_rdata;
  assign next_raddr = cmd_i.deq_slot ? head_rdata : free_head_q;

  gtq_ram #(.WIDTH(TW), .DEPTH(ELEMENTS)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bind_wr),
    .waddr_i (elem_q),
    .wdata_i (team_tab[req_q.team_id]),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (elem_q),
    .rdata_o (mem_rdata)
  );

  gtq_ram #(.WIDTH(CW), .DEPTH(TEAMS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_commit || cmd_i.deq_commit),
    .waddr_i (team_q),
    .wdata_i (cmd_i.deq_commit ? cnt_q - CW'(1) : cnt_cur + CW'(1)),
    .re_i    (cmd_i.enq_look || cmd_i.deq_look),
    .raddr_i (cmd_i.enq_look ? mem_rdata : order_rdata),
    .rdata_o (cnt_rdata)
  );

  gtq_ram #(.WIDTH(SW), .DEPTH(TEAMS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (team_q),
    .wdata_i (head_wdata),
    .re_i    (cmd_i.deq_look),
    .raddr_i (order_rdata),
    .rdata_o (head_rdata)
  );

  gtq_ram #(.WIDTH(SW), .DEPTH(TEAMS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_commit),
    .waddr_i (team_q),
    .wdata_i (free_head_q),
    .re_i    (cmd_i.enq_look),
    .raddr_i (mem_rdata),
    .rdata_o (tail_rdata)
  );

  gtq_ram #(.WIDTH(TW), .DEPTH(TEAMS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_commit && enq_new),
    .waddr_i (order_tail_q),
    .wdata_i (team_q),
    .re_i    (cmd_i.order_rd),
    .raddr_i (order_head_q),
    .rdata_o (order_rdata)
  );

  gtq_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_commit),
    .waddr_i (free_head_q),
    .wdata_i (ELEM_W'(elem_q)),
    .re_i    (cmd_i.deq_slot),
    .raddr_i (head_rdata),
    .rdata_o (val_rdata)
  );

  gtq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (free_head_q),
    .re_i    (cmd_i.enq_look || cmd_i.deq_slot),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.mod1) begin
      quo_q <= prod[35:24];
    end
    if (cmd_i.mod2) begin
      rem_q <= rem_full[EW:0];
    end
    if (cmd_i.mod3) begin
      elem_q <= (rem_q >= (EW+1)'(ELEMENTS)) ? EW'(rem_q - (EW+1)'(ELEMENTS)) : EW'(rem_q);
    end
    if (cmd_i.enq_look) begin
      team_q <= mem_rdata;
    end else if (cmd_i.deq_look) begin
      team_q <= order_rdata;
    end
    if (cmd_i.deq_slot) begin
      slot_q <= head_rdata;
      cnt_q  <= cnt_cur;
    end
    if (cmd_i.respond) begin
      rsp_q.status    <= cmd_i.status;
      rsp_q.out_value <= cmd_i.deq_commit ? val_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      free_head_q  <= '0;
      fresh_q      <= '0;
      order_head_q <= '0;
      order_tail_q <= '0;
      cnt_vld_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.respond;
      if (cmd_i.clear) begin
        total_q      <= '0;
        free_head_q  <= '0;
        fresh_q      <= '0;
        order_head_q <= '0;
        order_tail_q <= '0;
        cnt_vld_q    <= '0;
      end else if (cmd_i.enq_commit) begin
        total_q              <= total_q + CW'(1);
        free_head_q          <= next_free;
        cnt_vld_q[team_q]    <= 1'b1;
        if (fresh_hit) begin
          fresh_q <= fresh_q + (SW+1)'(1);
        end
        if (enq_new) begin
          order_tail_q <= (order_tail_q == TW'(TEAMS - 1)) ? '0 : order_tail_q + TW'(1);
        end
      end else if (cmd_i.deq_commit) begin
        total_q     <= total_q - CW'(1);
        free_head_q <= slot_q;
        if (cnt_q == CW'(1)) begin
          order_head_q <= (order_head_q == TW'(TEAMS - 1)) ? '0 : order_head_q + TW'(1);
        end
      end
    end
  end

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.full     = (total_q >= CW'(CAPACITY));
  assign sts_o.empty    = (total_q == '0);
  assign done_o         = done_q;
  assign rsp_o          = rsp_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(CAPACITY))
    else $error("queue count above capacity");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= (SW+1)'(CAPACITY))
    else $error("fresh slot mark above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (total_q == '0 && cnt_vld_q == '0))
    else $error("clear left queued words");

  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.respond && cmd_i.status == ST_EMPTY) |-> total_q == '0)
    else $error("empty status with queued words");

  a_deq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deq_commit |-> (cnt_q != '0 && total_q != '0))
    else $error("dequeue from team with no words");

endmodule

`default_nettype wire

>>> verif/gtq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gtq_checker
// Watches the request and response channels of the team queue, predicts
// each response from a behavioral model of the queue, and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module gtq_checker
  import gtq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t req_i,
  input  wire logic done_o,
  input  wire rsp_t rsp_o,
  output int        fail_cnt,
  output int        pending_cnt
);

  localparam int TEAMS    = DEF_TEAMS;
  localparam int CAPACITY = DEF_CAPACITY;

  logic [TEAM_W-1:0] team_of [DEF_ELEMENTS];
  int                team_fifo [TEAMS][$];
  int                team_order [$];
  int                queued;
  rsp_t              rsp_q [$];

  function automatic rsp_t queue_step(req_t r);
    rsp_t res;
    int   t;
    res = '0;
    res.status = ST_OK;
    case (r.req_type)
      REQ_BIND: team_of[r.element] = r.team_id;
      REQ_ENQ: begin
        if (queued >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          t = int'(team_of[r.element]);
          if (team_fifo[t].size() == 0) team_order.push_back(t);
          team_fifo[t].push_back(int'(r.element));
          queued++;
        end
      end
      REQ_DEQ: begin
        if (queued == 0) begin
          res.status = ST_EMPTY;
        end else begin
          t = team_order[0];
          res.out_value = ELEM_W'(team_fifo[t].pop_front());
          if (team_fifo[t].size() == 0) void'(team_order.pop_front());
          queued--;
        end
      end
      default: begin
        for (int i = 0; i < TEAMS; i++) team_fifo[i].delete();
        team_order.delete();
        queued = 0;
      end
    endcase
    return res;
  endfunction

  assign pending_cnt = rsp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      rsp_q.delete();
      team_order.delete();
      for (int i = 0; i < TEAMS; i++) team_fifo[i].delete();
      queued = 0;
      fail_cnt = 0;
    end else begin
      if (done_o) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected word: out_value %0d status %0d", rsp_o.out_value, rsp_o.status);
          fail_cnt++;
        end else begin
          want = rsp_q.pop_front();
          if (rsp_o.out_value !== want.out_value) begin
            $error("out_value: expected %0d actual %0d", want.out_value, rsp_o.out_value);
            fail_cnt++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp_o.status);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) rsp_q.push_back(queue_step(req_i));
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bind, enqueue, dequeue and clear requests into the team queue:
// a directed opening, then random runs of team traffic and one
// fill-to-full sequence, under varying sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gtq_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  int   fail_cnt;
  int   pending_cnt;
  int   gap_pct;
  bit   bound [DEF_ELEMENTS];
  int   bound_list [$];
  int   depth;
  int   fill;

  grouped_team_fifo_queue DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  gtq_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .fail_cnt   (fail_cnt),
    .pending_cnt(pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

  task automatic send(logic [REQ_W-1:0] op, int elem, int team);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{req_type: op, element: elem[ELEM_W-1:0], team_id: team[TEAM_W-1:0]};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    case (op)
      REQ_BIND: begin
        if (!bound[elem]) bound_list.push_back(elem);
        bound[elem] = 1'b1;
      end
      REQ_ENQ:  if (depth < DEF_CAPACITY) depth++;
      REQ_DEQ:  if (depth > 0) depth--;
      default:  depth = 0;
    endcase
  endtask

  function automatic int any_bound();
    return bound_list[$urandom_range(bound_list.size() - 1)];
  endfunction

  task automatic random_phase(int n);
    int sel;
    int burst;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send(REQ_BIND, $urandom_range(4095), $urandom_range(63));
      end else if (sel < 50) begin
        send(REQ_ENQ, any_bound(), $urandom_range(63));
      end else if (sel < 92) begin
        send(REQ_DEQ, $urandom_range(4095), $urandom_range(63));
      end else if (sel < 94) begin
        send(REQ_CLEAR, $urandom_range(4095), $urandom_range(63));
      end else begin
        burst = $urandom_range(20);
        for (int k = 0; k < burst; k++) send(REQ_ENQ, any_bound(), 0);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    gap_pct = 0;
    depth  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(REQ_DEQ, 0, 0);
    send(REQ_BIND, 0, 0);
    send(REQ_BIND, 4095, 63);
    send(REQ_BIND, 1, 63);
    send(REQ_BIND, 2, 5);
    send(REQ_ENQ, 4095, 0);
    send(REQ_ENQ, 0, 0);
    send(REQ_ENQ, 1, 0);
    send(REQ_ENQ, 2, 0);
    send(REQ_BIND, 1, 5);
    send(REQ_ENQ, 1, 0);
    send(REQ_ENQ, 0, 0);
    for (int k = 0; k < 7; k++) send(REQ_DEQ, 4095, 63);
    send(REQ_ENQ, 2, 0);
    send(REQ_CLEAR, 0, 0);
    send(REQ_DEQ, 0, 0);
    for (int b = 0; b < 64; b++) send(REQ_BIND, $urandom_range(4095), b);

    gap_pct = 34;
    random_phase(70);
    gap_pct = 77;
    random_phase(30);
    gap_pct = 0;
    fill = DEF_CAPACITY + 2 - depth;
    for (int k = 0; k < fill; k++) send(REQ_ENQ, any_bound(), 0);
    random_phase(50);
    start <= 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
